/* rtl/wrst_pkg.sv */
// ----------------------------------------------------------------------------
// wrst_pkg
// Shared types and constants for the weighted random selector table.
// ----------------------------------------------------------------------------
package wrst_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int TAG_BITS_DEF    = 16;
    localparam int WEIGHT_BITS     = 15;
    localparam int FRAC_BITS       = 16;
    localparam int FIELD_BITS      = 16;

    localparam logic [WEIGHT_BITS-1:0] ONE_Q8_8 = 15'd256;

    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_UNREGISTER = 2'd1,
        MODE_UPDATE     = 2'd2,
        MODE_SCHEDULE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EXISTS    = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCAN,
        S_WRITE,
        S_DIV,
        S_FINISH
    } state_t;

endpackage

/* rtl/wrst_cell.sv */
// ----------------------------------------------------------------------------
// wrst_cell
// One table entry of the rotating ring; loads its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module wrst_cell #(
    parameter int TAG_BITS = wrst_pkg::TAG_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              shift,
    input  logic [TAG_BITS-1:0]               nbr_tag,
    input  logic [wrst_pkg::WEIGHT_BITS-1:0]  nbr_weight,
    input  logic [wrst_pkg::FIELD_BITS-1:0]   nbr_latency,
    output logic [TAG_BITS-1:0]               tag,
    output logic [wrst_pkg::WEIGHT_BITS-1:0]  weight,
    output logic [wrst_pkg::FIELD_BITS-1:0]   latency
);

    logic [TAG_BITS-1:0]              tag_reg;
    logic [wrst_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic [wrst_pkg::FIELD_BITS-1:0]  latency_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tag_reg     <= nbr_tag;
            weight_reg  <= nbr_weight;
            latency_reg <= nbr_latency;
        end
    end

    assign tag     = tag_reg;
    assign weight  = weight_reg;
    assign latency = latency_reg;

endmodule

/* rtl/wrst_div.sv */
// ----------------------------------------------------------------------------
// wrst_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrst_div #(
    parameter int DVD_BITS = 31,
    parameter int DVS_BITS = 23,
    parameter int QUO_BITS = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                done,
    output logic [QUO_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DVD_BITS - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DVS_BITS:0]   rem_reg, rem_next;
    logic [DVD_BITS-1:0] dvd_reg, dvd_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS:0]   rem_shift;
    logic                qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_shift = {rem_reg[DVS_BITS-1:0], dvd_reg[DVD_BITS-1]};
        qbit      = (rem_shift >= {1'b0, dvs_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            dvd_next = {dvd_reg[DVD_BITS-2:0], 1'b0};
            quo_next = {quo_reg[QUO_BITS-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/weighted_random_selector_table.sv */
// A lookup that changes nothing takes one pass, a write takes a second pass that
// rotates the ring again, and a schedule adds the 31-step divider for confidence;
// each pass is one full rotation of the cell ring (N = MAX_ENTRIES cells).
// Throughput: one request at a time; the next is taken once the result is handed off.
// Reset clears the entry count, the weight total and all control; the table
// contents are undefined until written.
// ----------------------------------------------------------------------------
// weighted_random_selector_table
// Ordered agent table in a ring of cells with weighted random selection.
// ----------------------------------------------------------------------------
module weighted_random_selector_table #(
    parameter int MAX_ENTRIES = wrst_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = wrst_pkg::TAG_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [1:0]                                  mode,
    input  logic [wrst_pkg::FIELD_BITS-1:0]             agent_tag,
    input  logic signed [wrst_pkg::FIELD_BITS-1:0]      weight_in,
    input  logic [wrst_pkg::FIELD_BITS-1:0]             latency_in,
    input  logic [wrst_pkg::FRAC_BITS-1:0]              random_fraction,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [1:0]                                  status,
    output logic [wrst_pkg::FIELD_BITS-1:0]             selected_tag,
    output logic [wrst_pkg::FIELD_BITS-1:0]             confidence,
    output logic [wrst_pkg::FIELD_BITS-1:0]             estimated_time,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]            entries_in_use
);

    localparam int WB       = wrst_pkg::WEIGHT_BITS;
    localparam int FB       = wrst_pkg::FRAC_BITS;
    localparam int LB       = wrst_pkg::FIELD_BITS;
    localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_BITS = WB + $clog2(MAX_ENTRIES);
    localparam int DRAW_BITS = FB + TOT_BITS;
    localparam int QUO_BITS = FB + 1;
    localparam logic [CNT_BITS-1:0] LAST_SCAN  = CNT_BITS'(MAX_ENTRIES - 1);
    localparam logic [CNT_BITS-1:0] LAST_WRITE = CNT_BITS'(MAX_ENTRIES);
    localparam logic [CNT_BITS-1:0] FULL       = CNT_BITS'(MAX_ENTRIES);

    wrst_pkg::state_t  state_reg, state_next;
    wrst_pkg::mode_t   mode_reg, mode_next;
    wrst_pkg::status_t res_reg, res_next;

    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [WB-1:0]        w_reg, w_next;
    logic [LB-1:0]        lat_reg, lat_next;
    logic [FB-1:0]        frac_reg, frac_next;
    logic [DRAW_BITS-1:0] draw_reg, draw_next;
    logic [TOT_BITS-1:0]  cum_reg, cum_next;
    logic [TOT_BITS-1:0]  total_reg, total_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [TAG_BITS-1:0]  sel_tag_reg, sel_tag_next;
    logic [WB-1:0]        sel_w_reg, sel_w_next;
    logic [LB-1:0]        sel_lat_reg, sel_lat_next;
    logic [LB-1:0]        conf_reg, conf_next;
    logic [TAG_BITS-1:0]  d_tag_reg, d_tag_next;
    logic [WB-1:0]        d_w_reg, d_w_next;
    logic [LB-1:0]        d_lat_reg, d_lat_next;

    logic                 ov_reg, ov_next;
    logic [1:0]           o_status_reg, o_status_next;
    logic [LB-1:0]        o_tag_reg, o_tag_next;
    logic [LB-1:0]        o_conf_reg, o_conf_next;
    logic [LB-1:0]        o_est_reg, o_est_next;
    logic [CNT_BITS-1:0]  o_cnt_reg, o_cnt_next;

    // ring of cells: cell 0 is the head, the feed enters at the last cell
    logic [TAG_BITS-1:0]  c_tag [MAX_ENTRIES];
    logic [WB-1:0]        c_w   [MAX_ENTRIES];
    logic [LB-1:0]        c_lat [MAX_ENTRIES];
    logic [TAG_BITS-1:0]  feed_tag;
    logic [WB-1:0]        feed_w;
    logic [LB-1:0]        feed_lat;
    logic                 shift;

    logic                 div_start, div_done;
    logic [QUO_BITS-1:0]  quo;

    logic                 in_table, tag_hit, sched_hit, found_now, scan_last, write_last;
    logic [TOT_BITS-1:0]  cum_sum;
    logic                 out_free;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            if (gi == MAX_ENTRIES - 1)
            begin : g_tail
                wrst_cell #(.TAG_BITS(TAG_BITS)) u_cell (
                    .clk(clk), .shift(shift),
                    .nbr_tag(feed_tag), .nbr_weight(feed_w), .nbr_latency(feed_lat),
                    .tag(c_tag[gi]), .weight(c_w[gi]), .latency(c_lat[gi])
                );
            end
            else
            begin : g_body
                wrst_cell #(.TAG_BITS(TAG_BITS)) u_cell (
                    .clk(clk), .shift(shift),
                    .nbr_tag(c_tag[gi+1]), .nbr_weight(c_w[gi+1]),
                    .nbr_latency(c_lat[gi+1]),
                    .tag(c_tag[gi]), .weight(c_w[gi]), .latency(c_lat[gi])
                );
            end
        end
    endgenerate

    wrst_div #(
        .DVD_BITS(WB + FB),
        .DVS_BITS(TOT_BITS),
        .QUO_BITS(QUO_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend({sel_w_next, {FB{1'b0}}}),
        .divisor(total_reg),
        .done(div_done),
        .quotient(quo)
    );

    // per-step decisions at the head of the ring
    always_comb
    begin
        in_table   = (step_reg < count_reg);
        tag_hit    = in_table && (c_tag[0] == tag_reg);
        cum_sum    = cum_reg + TOT_BITS'(c_w[0]);
        sched_hit  = in_table && !found_reg &&
                     ((draw_reg <= {cum_sum, {FB{1'b0}}}) ||
                      (step_reg == count_reg - 1'b1));
        found_now  = found_reg || ((mode_reg == wrst_pkg::MODE_SCHEDULE) ? sched_hit : tag_hit);
        scan_last  = (step_reg == LAST_SCAN);
        write_last = (step_reg == LAST_WRITE);
        out_free   = !ov_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (wrst_pkg::mode_t'(mode) != wrst_pkg::MODE_SCHEDULE)
                        state_next = wrst_pkg::S_SCAN;
                    else if (count_reg == '0)
                        state_next = wrst_pkg::S_FINISH;
                    else
                        state_next = wrst_pkg::S_MUL;
                end
            end
            wrst_pkg::S_MUL:
                state_next = wrst_pkg::S_SCAN;
            wrst_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    unique case (mode_reg)
                        wrst_pkg::MODE_REGISTER:
                            state_next = (found_now || count_reg == FULL) ?
                                         wrst_pkg::S_FINISH : wrst_pkg::S_WRITE;
                        wrst_pkg::MODE_UNREGISTER,
                        wrst_pkg::MODE_UPDATE:
                            state_next = found_now ? wrst_pkg::S_WRITE : wrst_pkg::S_FINISH;
                        wrst_pkg::MODE_SCHEDULE:
                            state_next = wrst_pkg::S_DIV;
                        default:
                            state_next = wrst_pkg::S_FINISH;
                    endcase
                end
            end
            wrst_pkg::S_WRITE:
                if (write_last)
                    state_next = wrst_pkg::S_FINISH;
            wrst_pkg::S_DIV:
                if (div_done)
                    state_next = wrst_pkg::S_FINISH;
            wrst_pkg::S_FINISH:
                if (out_free)
                    state_next = wrst_pkg::S_IDLE;
            default:
                state_next = wrst_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        mode_next     = mode_reg;
        res_next      = res_reg;
        tag_next      = tag_reg;
        w_next        = w_reg;
        lat_next      = lat_reg;
        frac_next     = frac_reg;
        draw_next     = draw_reg;
        cum_next      = cum_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        sel_tag_next  = sel_tag_reg;
        sel_w_next    = sel_w_reg;
        sel_lat_next  = sel_lat_reg;
        conf_next     = conf_reg;
        d_tag_next    = d_tag_reg;
        d_w_next      = d_w_reg;
        d_lat_next    = d_lat_reg;
        ov_next       = ov_reg && !out_ready;
        o_status_next = o_status_reg;
        o_tag_next    = o_tag_reg;
        o_conf_next   = o_conf_reg;
        o_est_next    = o_est_reg;
        o_cnt_next    = o_cnt_reg;
        feed_tag      = d_tag_reg;
        feed_w        = d_w_reg;
        feed_lat      = d_lat_reg;
        shift         = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            wrst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next    = wrst_pkg::mode_t'(mode);
                    tag_next     = TAG_BITS'(agent_tag);
                    // zero or negative weight falls back to 1.0
                    w_next       = (weight_in <= 0) ? wrst_pkg::ONE_Q8_8 : weight_in[WB-1:0];
                    lat_next     = latency_in;
                    frac_next    = random_fraction;
                    res_next     = (wrst_pkg::mode_t'(mode) == wrst_pkg::MODE_SCHEDULE &&
                                    count_reg == '0) ? wrst_pkg::ST_NOT_FOUND : wrst_pkg::ST_OK;
                    step_next    = '0;
                    found_next   = 1'b0;
                    cum_next     = '0;
                    sel_tag_next = '0;
                    sel_w_next   = '0;
                    sel_lat_next = '0;
                    conf_next    = '0;
                end
            end
            wrst_pkg::S_MUL:
                draw_next = DRAW_BITS'(frac_reg) * DRAW_BITS'(total_reg);
            wrst_pkg::S_SCAN:
            begin
                shift     = 1'b1;
                feed_tag  = c_tag[0];
                feed_w    = c_w[0];
                feed_lat  = c_lat[0];
                step_next = scan_last ? '0 : step_reg + 1'b1;
                if (mode_reg == wrst_pkg::MODE_SCHEDULE)
                begin
                    if (in_table)
                        cum_next = cum_sum;
                    if (sched_hit)
                    begin
                        found_next   = 1'b1;
                        sel_tag_next = c_tag[0];
                        sel_w_next   = c_w[0];
                        sel_lat_next = c_lat[0];
                    end
                end
                else if (tag_hit && !found_reg)
                begin
                    found_next = 1'b1;
                    idx_next   = step_reg;
                    sel_w_next = c_w[0];
                end
                if (scan_last)
                begin
                    case (mode_reg)
                        wrst_pkg::MODE_REGISTER:
                            if (found_now)
                                res_next = wrst_pkg::ST_EXISTS;
                            else if (count_reg == FULL)
                                res_next = wrst_pkg::ST_FULL;
                        wrst_pkg::MODE_UNREGISTER:
                            if (!found_now)
                                res_next = wrst_pkg::ST_NOT_FOUND;
                        wrst_pkg::MODE_SCHEDULE:
                            div_start = 1'b1;
                        default:
                            res_next = res_reg;
                    endcase
                end
            end
            wrst_pkg::S_WRITE:
            begin
                // feed lands one place below its step index by the end of the write pass
                shift      = 1'b1;
                d_tag_next = c_tag[0];
                d_w_next   = c_w[0];
                d_lat_next = c_lat[0];
                step_next  = write_last ? '0 : step_reg + 1'b1;
                case (mode_reg)
                    wrst_pkg::MODE_REGISTER:
                        if (step_reg == CNT_BITS'(count_reg + 1'b1))
                        begin
                            feed_tag = tag_reg;
                            feed_w   = w_reg;
                            feed_lat = '0;
                        end
                    wrst_pkg::MODE_UNREGISTER:
                        if (step_reg > idx_reg)
                        begin
                            feed_tag = c_tag[0];
                            feed_w   = c_w[0];
                            feed_lat = c_lat[0];
                        end
                    wrst_pkg::MODE_UPDATE:
                        if (step_reg == CNT_BITS'(idx_reg + 1'b1))
                            feed_lat = lat_reg;
                    default:
                        feed_lat = d_lat_reg;
                endcase
                if (write_last)
                begin
                    if (mode_reg == wrst_pkg::MODE_REGISTER)
                    begin
                        count_next = count_reg + 1'b1;
                        total_next = total_reg + TOT_BITS'(w_reg);
                    end
                    else if (mode_reg == wrst_pkg::MODE_UNREGISTER)
                    begin
                        count_next = count_reg - 1'b1;
                        total_next = total_reg - TOT_BITS'(sel_w_reg);
                    end
                end
            end
            wrst_pkg::S_DIV:
                if (div_done)
                    conf_next = quo[QUO_BITS-1] ? {LB{1'b1}} : quo[LB-1:0];
            wrst_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = res_reg;
                    o_tag_next    = LB'(sel_tag_reg);
                    o_conf_next   = conf_reg;
                    o_est_next    = sel_lat_reg;
                    o_cnt_next    = count_reg;
                end
            end
            default:
                shift = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wrst_pkg::S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        res_reg      <= res_next;
        tag_reg      <= tag_next;
        w_reg        <= w_next;
        lat_reg      <= lat_next;
        frac_reg     <= frac_next;
        draw_reg     <= draw_next;
        cum_reg      <= cum_next;
        idx_reg      <= idx_next;
        sel_tag_reg  <= sel_tag_next;
        sel_w_reg    <= sel_w_next;
        sel_lat_reg  <= sel_lat_next;
        conf_reg     <= conf_next;
        d_tag_reg    <= d_tag_next;
        d_w_reg      <= d_w_next;
        d_lat_reg    <= d_lat_next;
        o_status_reg <= o_status_next;
        o_tag_reg    <= o_tag_next;
        o_conf_reg   <= o_conf_next;
        o_est_reg    <= o_est_next;
        o_cnt_reg    <= o_cnt_next;
    end

    assign in_ready       = (state_reg == wrst_pkg::S_IDLE);
    assign out_valid      = ov_reg;
    assign status         = o_status_reg;
    assign selected_tag   = o_tag_reg;
    assign confidence     = o_conf_reg;
    assign estimated_time = o_est_reg;
    assign entries_in_use = o_cnt_reg;

endmodule
